FILE: rtl/twcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcc_pkg
// shared types and constants of the three way coincidence counter
// ----------------------------------------------------------------------------
package twcc_pkg;

  localparam int HODO_SEGMENTS_DEF = 15;
  localparam int UP_SEGMENTS_DEF   = 22;
  localparam int DOWN_SEGMENTS_DEF = 32;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int CUT_W   = 24;
  localparam int RATIO_W = 17;
  localparam int PADDR_W = 4;

  localparam logic [CUT_W-1:0]   CUT_HODO_RST = 24'd100000;
  localparam logic [CUT_W-1:0]   CUT_UP_RST   = 24'd40000;
  localparam logic [CUT_W-1:0]   CUT_DOWN_RST = 24'd40000;
  localparam logic [RATIO_W-1:0] RATIO_FULL   = 17'd100000;

  // register indexes
  typedef enum logic [1:0] {
    REG_CUT_HODO = 2'd0,
    REG_CUT_UP   = 2'd1,
    REG_CUT_DOWN = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_HIT   = 2'd0,
    REQ_EOE   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    DET_HODO = 2'd0,
    DET_UP   = 2'd1,
    DET_DOWN = 2'd2,
    DET_NONE = 2'd3
  } det_e;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_EOE, ST_HS, ST_HW, ST_US, ST_DS, ST_TW,
    ST_QRD, ST_QMUL, ST_QINIT, ST_QDIV, ST_QOUT
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic hit;
    logic q_latch;
    logic mask_clr;
    logic any_inc;
    logic h_clr;
    logic h_inc;
    logic u_clr;
    logic u_inc;
    logic d_clr;
    logic d_inc;
    logic hodo_rd;
    logic hodo_wr;
    logic tri_rd;
    logic tri_wr;
    logic q_rd;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic h_any;
    logic h_bit;
    logic h_last;
    logic u_bit;
    logic u_last;
    logic d_bit;
    logic d_last;
    logic q_oor;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/twcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcc_ctrl
// sequencer: clearing sweep, end of event walk, query and division steps
// ----------------------------------------------------------------------------
module twcc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      req_type_i,
  output logic            in_stall_o,
  input  twcc_pkg::stat_t stat_i,
  output twcc_pkg::cmd_t  cmd_o
);
  import twcc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_e'(req_type_i))
            REQ_HIT:   cmd_o.hit = 1'b1;
            REQ_EOE:   state_d = ST_EOE;
            REQ_QUERY: begin
              cmd_o.q_latch = 1'b1;
              state_d       = ST_QRD;
            end
            default: ;
          endcase
        end
      end
      ST_EOE: begin
        if (stat_i.h_any) begin
          cmd_o.any_inc = 1'b1;
          cmd_o.h_clr   = 1'b1;
          state_d       = ST_HS;
        end else begin
          cmd_o.mask_clr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_HS: begin
        if (stat_i.h_bit) begin
          cmd_o.hodo_rd = 1'b1;
          state_d       = ST_HW;
        end else if (!stat_i.h_last) begin
          cmd_o.h_inc = 1'b1;
        end else begin
          cmd_o.mask_clr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_HW: begin
        cmd_o.hodo_wr = 1'b1;
        cmd_o.u_clr   = 1'b1;
        state_d       = ST_US;
      end
      ST_US, ST_DS, ST_TW: begin
        // advance d, then u, then h as each runs out
        if (state_q == ST_US && stat_i.u_bit) begin
          cmd_o.d_clr = 1'b1;
          state_d     = ST_DS;
        end else if (state_q == ST_DS && stat_i.d_bit) begin
          cmd_o.tri_rd = 1'b1;
          state_d      = ST_TW;
        end else begin
          if (state_q == ST_TW) cmd_o.tri_wr = 1'b1;
          if (state_q != ST_US && !stat_i.d_last) begin
            cmd_o.d_inc = 1'b1;
            state_d     = ST_DS;
          end else if (!stat_i.u_last) begin
            cmd_o.u_inc = 1'b1;
            state_d     = ST_US;
          end else if (!stat_i.h_last) begin
            cmd_o.h_inc = 1'b1;
            state_d     = ST_HS;
          end else begin
            cmd_o.mask_clr = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_QRD: begin
        if (stat_i.q_oor) begin
          state_d = ST_QOUT;
        end else begin
          cmd_o.q_rd = 1'b1;
          state_d    = ST_QMUL;
        end
      end
      ST_QMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_QINIT;
      end
      ST_QINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_QDIV;
      end
      ST_QDIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_QOUT;
      end
      ST_QOUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/twcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcc_datapath
// event masks, count memories, walk indexes, ratio divider and result register
// ----------------------------------------------------------------------------
module twcc_datapath #(
  parameter int HODO_SEGMENTS = twcc_pkg::HODO_SEGMENTS_DEF,
  parameter int UP_SEGMENTS   = twcc_pkg::UP_SEGMENTS_DEF,
  parameter int DOWN_SEGMENTS = twcc_pkg::DOWN_SEGMENTS_DEF,
  parameter int COUNT_WIDTH   = twcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  twcc_pkg::cmd_t                 cmd_i,
  output twcc_pkg::stat_t                stat_o,
  input  logic [twcc_pkg::CUT_W-1:0]     cut_hodo_i,
  input  logic [twcc_pkg::CUT_W-1:0]     cut_up_i,
  input  logic [twcc_pkg::CUT_W-1:0]     cut_down_i,
  input  logic [1:0]                     detector_i,
  input  logic [5:0]                     segment_i,
  input  logic [twcc_pkg::CUT_W-1:0]     energy_ev_i,
  input  logic [5:0]                     query_hodo_i,
  input  logic [5:0]                     query_up_i,
  input  logic [5:0]                     query_down_i,
  input  logic                           denom_any_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           status_o,
  output logic [31:0]                    numerator_o,
  output logic [31:0]                    denominator_o,
  output logic [twcc_pkg::RATIO_W-1:0]   ratio_milli_percent_o
);
  import twcc_pkg::*;

  localparam int TD  = HODO_SEGMENTS * UP_SEGMENTS * DOWN_SEGMENTS;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
  localparam int HAW = (HODO_SEGMENTS > 1) ? $clog2(HODO_SEGMENTS) : 1;
  localparam int UAW = (UP_SEGMENTS > 1) ? $clog2(UP_SEGMENTS) : 1;
  localparam int DAW = (DOWN_SEGMENTS > 1) ? $clog2(DOWN_SEGMENTS) : 1;
  localparam int CW  = COUNT_WIDTH;
  localparam int PW  = CW + RATIO_W;

  function automatic logic [31:0] sat32(input logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + CW'(1);
  endfunction

  function automatic logic [TAW-1:0] tri_addr(input logic [HAW-1:0] h,
                                               input logic [UAW-1:0] u,
                                               input logic [DAW-1:0] d);
    return (TAW'(h) * TAW'(UP_SEGMENTS) + TAW'(u)) * TAW'(DOWN_SEGMENTS) + TAW'(d);
  endfunction

  logic [HODO_SEGMENTS-1:0] hmask_q;
  logic [UP_SEGMENTS-1:0]   umask_q;
  logic [DOWN_SEGMENTS-1:0] dmask_q;
  logic [HAW-1:0]           h_q;
  logic [UAW-1:0]           u_q;
  logic [DAW-1:0]           d_q;
  logic [TAW-1:0]           clr_q;
  logic [CW-1:0]            any_cnt_q;

  logic [5:0]               qh_q, qu_q, qd_q;
  logic                     qany_q;
  logic                     oor;

  logic [CW-1:0]            tri_mem [TD];
  logic [CW-1:0]            hodo_mem [HODO_SEGMENTS];
  logic [CW-1:0]            tri_rd_q, hodo_rd_q;
  logic [TAW-1:0]           tri_raddr, tri_waddr;
  logic [HAW-1:0]           hodo_raddr, hodo_waddr;
  logic [CW-1:0]            tri_wdata, hodo_wdata;
  logic                     tri_we, hodo_we;

  logic [CW-1:0]            num_q, den_q, dv_q, den_sel;
  logic [PW-1:0]            prod_q;
  logic [CW-1:0]            rem_q;
  logic [RATIO_W-1:0]       lo_q, quot_q;
  logic [4:0]               cnt_q;
  logic [CW:0]              r2;
  logic                     ge;

  logic                     out_valid_q;

  // hit acceptance
  logic hit_h, hit_u, hit_d;
  assign hit_h = cmd_i.hit && det_e'(detector_i) == DET_HODO && energy_ev_i > cut_hodo_i
                 && {1'b0, segment_i} < 7'(HODO_SEGMENTS);
  assign hit_u = cmd_i.hit && det_e'(detector_i) == DET_UP && energy_ev_i > cut_up_i
                 && {1'b0, segment_i} < 7'(UP_SEGMENTS);
  assign hit_d = cmd_i.hit && det_e'(detector_i) == DET_DOWN && energy_ev_i > cut_down_i
                 && {1'b0, segment_i} < 7'(DOWN_SEGMENTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmask_q   <= '0;
      umask_q   <= '0;
      dmask_q   <= '0;
      any_cnt_q <= '0;
      clr_q     <= '0;
    end else begin
      if (cmd_i.mask_clr) begin
        hmask_q <= '0;
        umask_q <= '0;
        dmask_q <= '0;
      end else begin
        if (hit_h) hmask_q[segment_i[HAW-1:0]] <= 1'b1;
        if (hit_u) umask_q[segment_i[UAW-1:0]] <= 1'b1;
        if (hit_d) dmask_q[segment_i[DAW-1:0]] <= 1'b1;
      end
      if (cmd_i.any_inc) any_cnt_q <= sat_inc(any_cnt_q);
      if (cmd_i.clr_we) clr_q <= clr_q + TAW'(1);
    end
  end

  // walk indexes and latched query
  always_ff @(posedge clk_i) begin
    if (cmd_i.h_clr) h_q <= '0;
    else if (cmd_i.h_inc) h_q <= h_q + HAW'(1);
    if (cmd_i.u_clr) u_q <= '0;
    else if (cmd_i.u_inc) u_q <= u_q + UAW'(1);
    if (cmd_i.d_clr) d_q <= '0;
    else if (cmd_i.d_inc) d_q <= d_q + DAW'(1);
    if (cmd_i.q_latch) begin
      qh_q   <= query_hodo_i;
      qu_q   <= query_up_i;
      qd_q   <= query_down_i;
      qany_q <= denom_any_i;
    end
  end

  assign oor = ({1'b0, qh_q} >= 7'(HODO_SEGMENTS)) || ({1'b0, qu_q} >= 7'(UP_SEGMENTS))
               || ({1'b0, qd_q} >= 7'(DOWN_SEGMENTS));

  // count memories
  assign tri_raddr  = cmd_i.q_rd ? tri_addr(qh_q[HAW-1:0], qu_q[UAW-1:0], qd_q[DAW-1:0])
                                 : tri_addr(h_q, u_q, d_q);
  assign tri_waddr  = cmd_i.clr_we ? clr_q : tri_addr(h_q, u_q, d_q);
  assign tri_wdata  = cmd_i.clr_we ? '0 : sat_inc(tri_rd_q);
  assign tri_we     = cmd_i.clr_we || cmd_i.tri_wr;
  assign hodo_raddr = cmd_i.q_rd ? qh_q[HAW-1:0] : h_q;
  assign hodo_waddr = cmd_i.clr_we ? clr_q[HAW-1:0] : h_q;
  assign hodo_wdata = cmd_i.clr_we ? '0 : sat_inc(hodo_rd_q);
  assign hodo_we    = (cmd_i.clr_we && clr_q < TAW'(HODO_SEGMENTS)) || cmd_i.hodo_wr;

  always_ff @(posedge clk_i) begin
    if (tri_we) tri_mem[tri_waddr] <= tri_wdata;
    if (cmd_i.tri_rd || cmd_i.q_rd) tri_rd_q <= tri_mem[tri_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hodo_we) hodo_mem[hodo_waddr] <= hodo_wdata;
    if (cmd_i.hodo_rd || cmd_i.q_rd) hodo_rd_q <= hodo_mem[hodo_raddr];
  end

  // ratio: restoring division of 100000 * num by the floored denominator
  assign den_sel = qany_q ? any_cnt_q : hodo_rd_q;
  assign r2      = {rem_q, lo_q[RATIO_W-1]};
  assign ge      = r2 >= {1'b0, dv_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q  <= tri_rd_q;
      den_q  <= den_sel;
      dv_q   <= (den_sel == '0) ? CW'(1) : den_sel;
      prod_q <= PW'(tri_rd_q) * PW'(RATIO_FULL);
    end
    if (cmd_i.div_init) begin
      rem_q  <= prod_q[PW-1:RATIO_W];
      lo_q   <= prod_q[RATIO_W-1:0];
      quot_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? CW'(r2 - {1'b0, dv_q}) : r2[CW-1:0];
      lo_q   <= {lo_q[RATIO_W-2:0], 1'b0};
      quot_q <= {quot_q[RATIO_W-2:0], ge};
      cnt_q  <= cnt_q + 5'd1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= oor;
      if (oor) begin
        numerator_o           <= '0;
        denominator_o         <= '0;
        ratio_milli_percent_o <= '0;
      end else begin
        numerator_o           <= sat32(num_q);
        denominator_o         <= sat32(den_q);
        ratio_milli_percent_o <= (num_q >= dv_q) ? RATIO_FULL : quot_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.clr_last = clr_q == TAW'(TD - 1);
  assign stat_o.h_any    = |hmask_q;
  assign stat_o.h_bit    = hmask_q[h_q];
  assign stat_o.h_last   = h_q == HAW'(HODO_SEGMENTS - 1);
  assign stat_o.u_bit    = umask_q[u_q];
  assign stat_o.u_last   = u_q == UAW'(UP_SEGMENTS - 1);
  assign stat_o.d_bit    = dmask_q[d_q];
  assign stat_o.d_last   = d_q == DAW'(DOWN_SEGMENTS - 1);
  assign stat_o.q_oor    = oor;
  assign stat_o.div_last = cnt_q == 5'(RATIO_W - 1);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

FILE: rtl/three_way_coincidence_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_way_coincidence_counter
// coincidence scaler over hodoscope, upstream and downstream veto segments
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  req_type, detector, segment, energy_ev,
//                                            query_hodo, query_up, query_down, denom_any
// out      output     out_valid_o/out_stall_i status, numerator, denominator,
//                                            ratio_milli_percent
// cfg      apb        psel/penable/pwrite    cut_hodo_ev, cut_up_ev, cut_down_ev
//
// a hit is taken in the idle state without leaving it; end of event steps through each hodoscope
// segment, each upstream segment of each hit hodoscope segment and each downstream
// segment of each hit pair, with a single port read then write per hit hodoscope
// segment and per hit triple
// an in-range query runs through the 17 step restoring divider; an out of range
// query skips it; either holds before loading its result while a stalled
// result still sits in the output register
// after reset the triple and hodoscope memories are swept to zero, one entry a cycle,
// HODO*UP*DOWN entries (10560 by default), with in_stall_o high
// a pending result may wait on out_stall_i while the next transfer is taken in
// ----------------------------------------------------------------------------
module three_way_coincidence_counter #(
  parameter int HODO_SEGMENTS = twcc_pkg::HODO_SEGMENTS_DEF,
  parameter int UP_SEGMENTS   = twcc_pkg::UP_SEGMENTS_DEF,
  parameter int DOWN_SEGMENTS = twcc_pkg::DOWN_SEGMENTS_DEF,
  parameter int COUNT_WIDTH   = twcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [twcc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [1:0]                   detector_i,
  input  logic [5:0]                   segment_i,
  input  logic [twcc_pkg::CUT_W-1:0]   energy_ev_i,
  input  logic [5:0]                   query_hodo_i,
  input  logic [5:0]                   query_up_i,
  input  logic [5:0]                   query_down_i,
  input  logic                         denom_any_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [31:0]                  numerator_o,
  output logic [31:0]                  denominator_o,
  output logic [twcc_pkg::RATIO_W-1:0] ratio_milli_percent_o
);
  import twcc_pkg::*;

  logic [CUT_W-1:0] cut_hodo_q, cut_up_q, cut_down_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;
  cmd_t             cmd;
  stat_t            stat;

  // configuration registers, word addressed
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_hodo_q <= CUT_HODO_RST;
      cut_up_q   <= CUT_UP_RST;
      cut_down_q <= CUT_DOWN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CUT_HODO: cut_hodo_q <= pwdata[CUT_W-1:0];
        REG_CUT_UP:   cut_up_q   <= pwdata[CUT_W-1:0];
        REG_CUT_DOWN: cut_down_q <= pwdata[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CUT_HODO: prdata = 32'(cut_hodo_q);
      REG_CUT_UP:   prdata = 32'(cut_up_q);
      REG_CUT_DOWN: prdata = 32'(cut_down_q);
      default:      prdata = '0;
    endcase
  end

  // sequencer
  twcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // masks, counters, divider and result register
  twcc_datapath #(
    .HODO_SEGMENTS (HODO_SEGMENTS),
    .UP_SEGMENTS   (UP_SEGMENTS),
    .DOWN_SEGMENTS (DOWN_SEGMENTS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cut_hodo_i            (cut_hodo_q),
    .cut_up_i              (cut_up_q),
    .cut_down_i            (cut_down_q),
    .detector_i            (detector_i),
    .segment_i             (segment_i),
    .energy_ev_i           (energy_ev_i),
    .query_hodo_i          (query_hodo_i),
    .query_up_i            (query_up_i),
    .query_down_i          (query_down_i),
    .denom_any_i           (denom_any_i),
    .out_stall_i           (out_stall_i),
    .out_valid_o           (out_valid_o),
    .status_o              (status_o),
    .numerator_o           (numerator_o),
    .denominator_o         (denominator_o),
    .ratio_milli_percent_o (ratio_milli_percent_o)
  );

endmodule
